### rtl/core/slc_pkg.sv
// Shared constants, types and helpers for the substring compare block.
package slc_pkg;

  localparam int MAX_LEN    = 4096;
  localparam int LEVELS     = 13;
  localparam int POS_W      = $clog2(MAX_LEN);
  localparam int LEN_W      = POS_W + 1;
  localparam int LVL_W      = $clog2(LEVELS);
  localparam int RANK_W     = LEN_W;
  localparam int CODE_W     = 5;
  localparam int RANK_AW    = LVL_W + POS_W;
  localparam int RANK_DEPTH = LEVELS * MAX_LEN;
  localparam int KEY_DEPTH  = MAX_LEN + 1;
  localparam int KEY_AW     = $clog2(KEY_DEPTH);

  localparam logic [6:0] LETTER_A = 7'd97;
  localparam logic [6:0] LETTER_Z = 7'd122;
  localparam logic [CODE_W-1:0] CODE_FIRST = 5'd1;
  localparam logic [CODE_W-1:0] CODE_LAST  = 5'd26;

  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_COMPARE = 1'b1;

  localparam logic [1:0] VERDICT_LESS    = 2'd0;
  localparam logic [1:0] VERDICT_EQUAL   = 2'd1;
  localparam logic [1:0] VERDICT_GREATER = 2'd2;
  localparam logic [1:0] VERDICT_INVALID = 2'd3;

  // one write port, two read ports of the rank table
  typedef struct packed {
    logic               we;
    logic [RANK_AW-1:0] waddr;
    logic [RANK_W-1:0]  wdata;
    logic [RANK_AW-1:0] raddr0;
    logic [RANK_AW-1:0] raddr1;
  } rank_port_t;

  function automatic logic [RANK_AW-1:0] rank_addr(input logic [LVL_W-1:0] lvl,
                                                   input logic [POS_W-1:0] pos);
    rank_addr = {lvl, pos};
  endfunction

endpackage

### rtl/core/substring_lexicographic_compare.sv
// Top level: letter load, rank table build and substring compare.
//
//  channel | handshake          | words
//  --------+--------------------+---------------------------------------------
//  in      | start & !busy      | command, letter, last_letter, first/second
//          |                    | start and end
//  out     | done (one cycle)   | verdict
//
// A load word without last_letter leaves busy low, so load words can follow
// back to back. A load word with last_letter set starts the table build: a
// copy of the letters, then per level two sort passes of count clearing,
// histogram, prefix sums and scatter, then ranking.
// A compare word compares rank table blocks from the top level down over the
// shorter length; the invalid case answers straight from idle.
// Reset is synchronous; memories are not cleared, the table is valid only
// after a build. busy is high during a build, through its finishing cycle, and
// during a compare. The receiver cannot stall: done is never held off.
module substring_lexicographic_compare (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic                      command,
  input  logic [6:0]                letter,
  input  logic                      last_letter,
  input  logic [slc_pkg::LEN_W-1:0] first_start,
  input  logic [slc_pkg::LEN_W-1:0] first_end,
  input  logic [slc_pkg::LEN_W-1:0] second_start,
  input  logic [slc_pkg::LEN_W-1:0] second_end,
  output logic                      done,
  output logic [1:0]                verdict
);
  import slc_pkg::*;

  logic [LEN_W-1:0]  string_length;
  logic              table_ready;
  logic              build_pend;

  logic              accept, load_acc, query_acc;
  logic [LEN_W-1:0]  len_base;
  logic [CODE_W-1:0] code;

  logic              b_busy, b_done, q_busy;
  logic [POS_W-1:0]  letter_raddr;
  logic [CODE_W-1:0] letter_rd;
  rank_port_t        b_port, q_port, r_port;
  logic [RANK_W-1:0] rank_rd0, rank_rd1;

  // b_done cycle: table_ready not yet set, so no word is taken then
  assign busy      = build_pend || b_busy || b_done || q_busy;
  assign accept    = start && !busy;
  assign load_acc  = accept && (command == CMD_LOAD);
  assign query_acc = accept && (command == CMD_COMPARE);
  // a load after a finished build starts a fresh string
  assign len_base  = table_ready ? '0 : string_length;

  // out-of-range bytes clamp to the nearest letter
  always_comb begin
    priority if (letter < LETTER_A) begin
      code = CODE_FIRST;
    end else if (letter > LETTER_Z) begin
      code = CODE_LAST;
    end else begin
      code = CODE_W'(letter - LETTER_A) + CODE_FIRST;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      string_length <= '0;
      table_ready   <= 1'b0;
      build_pend    <= 1'b0;
    end else begin
      build_pend <= 1'b0;
      if (b_done) begin
        table_ready <= 1'b1;
      end
      if (load_acc) begin
        table_ready <= 1'b0;
        // once the store is full further letters are dropped
        string_length <= (len_base < LEN_W'(MAX_LEN)) ? len_base + LEN_W'(1) : len_base;
        build_pend    <= last_letter;
      end
    end
  end

  // letter store: written on load, read by the builder
  slc_ram #(.DEPTH(MAX_LEN), .WIDTH(CODE_W), .AW(POS_W)) u_letters (
    .clk(clk),
    .we(load_acc && (len_base < LEN_W'(MAX_LEN))),
    .waddr(len_base[POS_W-1:0]),
    .wdata(code),
    .raddr0(letter_raddr),
    .raddr1(letter_raddr),
    .rdata0(letter_rd),
    .rdata1()
  );

  slc_build u_build (
    .clk(clk),
    .rst(rst),
    .go(build_pend),
    .n(string_length),
    .busy(b_busy),
    .done(b_done),
    .letter_raddr(letter_raddr),
    .letter_rdata(letter_rd),
    .rank_port(b_port),
    .rank_rd0(rank_rd0),
    .rank_rd1(rank_rd1)
  );

  slc_query u_query (
    .clk(clk),
    .rst(rst),
    .go(query_acc),
    .ready(table_ready),
    .n(string_length),
    .first_start(first_start),
    .first_end(first_end),
    .second_start(second_start),
    .second_end(second_end),
    .rank_port(q_port),
    .rank_rd0(rank_rd0),
    .rank_rd1(rank_rd1),
    .busy(q_busy),
    .done(done),
    .verdict(verdict)
  );

  // builder and query never run together; the builder owns the table while busy
  assign r_port = b_busy ? b_port : q_port;

  // rank table: level in the upper address bits, position below
  slc_ram #(.DEPTH(RANK_DEPTH), .WIDTH(RANK_W), .AW(RANK_AW)) u_ranks (
    .clk(clk),
    .we(r_port.we),
    .waddr(r_port.waddr),
    .wdata(r_port.wdata),
    .raddr0(r_port.raddr0),
    .raddr1(r_port.raddr1),
    .rdata0(rank_rd0),
    .rdata1(rank_rd1)
  );

`ifndef SYNTHESIS
  a_exclusive: assert property (@(posedge clk) disable iff (rst) !(b_busy && q_busy))
    else $error("build and query active together");
  a_ready_len: assert property (@(posedge clk) disable iff (rst)
    table_ready |-> (string_length != '0))
    else $error("table ready with empty string");
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !b_busy)
    else $error("result during build");
  a_build_start: assert property (@(posedge clk) disable iff (rst) build_pend |=> b_busy)
    else $error("build did not start");
`endif

endmodule

### rtl/core/slc_ram.sv
// Generic RAM: one write port, two registered read ports.
module slc_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 8,
  parameter int AW    = 12
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr0,
  input  logic [AW-1:0]    raddr1,
  output logic [WIDTH-1:0] rdata0,
  output logic [WIDTH-1:0] rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

### rtl/core/slc_build.sv
// Rank table builder: doubling passes with two counting sorts per level.
module slc_build (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       go,
  input  logic [slc_pkg::LEN_W-1:0]  n,
  output logic                       busy,
  output logic                       done,
  output logic [slc_pkg::POS_W-1:0]  letter_raddr,
  input  logic [slc_pkg::CODE_W-1:0] letter_rdata,
  output slc_pkg::rank_port_t        rank_port,
  input  logic [slc_pkg::RANK_W-1:0] rank_rd0,
  input  logic [slc_pkg::RANK_W-1:0] rank_rd1
);
  import slc_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_COPY = 3'd1;
  localparam logic [2:0] S_LVL  = 3'd2;
  localparam logic [2:0] S_CLR  = 3'd3;
  localparam logic [2:0] S_HIST = 3'd4;
  localparam logic [2:0] S_PFX  = 3'd5;
  localparam logic [2:0] S_SCAT = 3'd6;
  localparam logic [2:0] S_RANK = 3'd7;

  logic [2:0]        state;
  logic [1:0]        ph;
  logic              pass;       // 0: sort on second half, 1: on first half
  logic [LVL_W-1:0]  lvl;
  logic [LEN_W-1:0]  j;
  logic [POS_W-1:0]  jsel;
  logic [KEY_AW-1:0] key;
  logic [LEN_W-1:0]  sum;
  logic [RANK_W-1:0] next_rank;
  logic [RANK_W-1:0] pa_q, pb_q;

  logic [LVL_W-1:0]  prev_lvl;
  logic [POS_W-1:0]  half;
  logic [POS_W-1:0]  j_pos;
  logic [LEN_W-1:0]  last_idx;
  logic              lvl_ok;
  logic              is_new;
  logic [RANK_W-1:0] new_rank;

  logic              cnt_we;
  logic [KEY_AW-1:0] cnt_waddr, cnt_raddr;
  logic [LEN_W-1:0]  cnt_wdata, cnt_rd;
  logic [LEN_W-1:0]  cnt_dec;
  logic              bs_we, bp_we;
  logic [POS_W-1:0]  bs_raddr, bp_raddr, bs_rd, bp_rd;

  assign prev_lvl = lvl - LVL_W'(1);
  assign half     = POS_W'(1) << prev_lvl;
  assign j_pos    = j[POS_W-1:0];
  assign last_idx = n - (LEN_W'(1) << lvl);
  assign lvl_ok   = (lvl < LVL_W'(LEVELS)) && ((LEN_W'(1) << lvl) <= n);
  assign cnt_dec  = cnt_rd - LEN_W'(1);
  assign is_new   = (j == '0) || (rank_rd0 != pa_q) || (rank_rd1 != pb_q);
  assign new_rank = is_new ? next_rank + RANK_W'(1) : next_rank;
  assign busy     = (state != S_IDLE);

  always_comb begin
    rank_port        = '0;
    rank_port.raddr1 = rank_addr(prev_lvl, bp_rd + half);
    letter_raddr     = j_pos;
    cnt_we           = 1'b0;
    cnt_waddr        = key;
    cnt_wdata        = '0;
    cnt_raddr        = KEY_AW'(rank_rd0);
    bs_we            = 1'b0;
    bp_we            = 1'b0;
    bs_raddr         = j_pos;
    bp_raddr         = j_pos;
    unique case (state)
      S_COPY: begin
        rank_port.we    = (ph == 2'd1);
        rank_port.waddr = rank_addr('0, j_pos);
        rank_port.wdata = RANK_W'(letter_rdata);
      end
      S_CLR: begin
        cnt_we    = 1'b1;
        cnt_waddr = KEY_AW'(j);
      end
      S_HIST: begin
        rank_port.raddr0 = rank_addr(prev_lvl, pass ? j_pos : j_pos + half);
        cnt_we    = (ph == 2'd2);
        cnt_wdata = cnt_rd + LEN_W'(1);
      end
      S_PFX: begin
        cnt_raddr = KEY_AW'(j);
        cnt_we    = (ph == 2'd1);
        cnt_waddr = KEY_AW'(j);
        cnt_wdata = sum + cnt_rd;
      end
      S_SCAT: begin
        rank_port.raddr0 = rank_addr(prev_lvl, (ph == 2'd1) ? bs_rd : j_pos + half);
        cnt_we    = (ph == 2'd3);
        cnt_wdata = cnt_dec;
        bs_we     = (ph == 2'd3) && !pass;
        bp_we     = (ph == 2'd3) && pass;
      end
      S_RANK: begin
        rank_port.raddr0 = rank_addr(prev_lvl, bp_rd);
        rank_port.we     = (ph == 2'd2);
        rank_port.waddr  = rank_addr(lvl, jsel);
        rank_port.wdata  = new_rank;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ph    <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (go) begin
            state <= S_COPY;
            j     <= '0;
            ph    <= '0;
          end
        end
        S_COPY: begin
          if (ph == 2'd0) begin
            ph <= 2'd1;
          end else begin
            ph <= 2'd0;
            if (j == n - LEN_W'(1)) begin
              lvl   <= LVL_W'(1);
              state <= S_LVL;
            end else begin
              j <= j + LEN_W'(1);
            end
          end
        end
        S_LVL: begin
          if (lvl_ok) begin
            state <= S_CLR;
            pass  <= 1'b0;
            j     <= '0;
          end else begin
            state <= S_IDLE;
            done  <= 1'b1;
          end
        end
        S_CLR: begin
          if (j == LEN_W'(MAX_LEN)) begin
            j     <= '0;
            ph    <= '0;
            state <= S_HIST;
          end else begin
            j <= j + LEN_W'(1);
          end
        end
        S_HIST: begin
          unique case (ph)
            2'd0: ph <= 2'd1;
            2'd1: begin
              key <= KEY_AW'(rank_rd0);
              ph  <= 2'd2;
            end
            default: begin
              ph <= 2'd0;
              if (j == last_idx) begin
                j     <= '0;
                sum   <= '0;
                state <= S_PFX;
              end else begin
                j <= j + LEN_W'(1);
              end
            end
          endcase
        end
        S_PFX: begin
          if (ph == 2'd0) begin
            ph <= 2'd1;
          end else begin
            ph  <= 2'd0;
            sum <= sum + cnt_rd;
            if (j == LEN_W'(MAX_LEN)) begin
              j     <= last_idx;
              state <= S_SCAT;
            end else begin
              j <= j + LEN_W'(1);
            end
          end
        end
        S_SCAT: begin
          unique case (ph)
            2'd0: begin
              if (pass) begin
                ph <= 2'd1;
              end else begin
                jsel <= j_pos;
                ph   <= 2'd2;
              end
            end
            2'd1: begin
              jsel <= bs_rd;
              ph   <= 2'd2;
            end
            2'd2: begin
              key <= KEY_AW'(rank_rd0);
              ph  <= 2'd3;
            end
            default: begin
              ph <= 2'd0;
              if (j == '0) begin
                if (pass) begin
                  state     <= S_RANK;
                  next_rank <= '0;
                end else begin
                  pass  <= 1'b1;
                  state <= S_CLR;
                end
              end else begin
                j <= j - LEN_W'(1);
              end
            end
          endcase
        end
        S_RANK: begin
          unique case (ph)
            2'd0: ph <= 2'd1;
            2'd1: begin
              jsel <= bp_rd;
              ph   <= 2'd2;
            end
            default: begin
              ph        <= 2'd0;
              next_rank <= new_rank;
              pa_q      <= rank_rd0;
              pb_q      <= rank_rd1;
              if (j == last_idx) begin
                lvl   <= lvl + LVL_W'(1);
                state <= S_LVL;
              end else begin
                j <= j + LEN_W'(1);
              end
            end
          endcase
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  slc_ram #(.DEPTH(KEY_DEPTH), .WIDTH(LEN_W), .AW(KEY_AW)) u_cnt (
    .clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
    .raddr0(cnt_raddr), .raddr1(cnt_raddr), .rdata0(cnt_rd), .rdata1()
  );

  slc_ram #(.DEPTH(MAX_LEN), .WIDTH(POS_W), .AW(POS_W)) u_by_second (
    .clk(clk), .we(bs_we), .waddr(cnt_dec[POS_W-1:0]), .wdata(jsel),
    .raddr0(bs_raddr), .raddr1(bs_raddr), .rdata0(bs_rd), .rdata1()
  );

  slc_ram #(.DEPTH(MAX_LEN), .WIDTH(POS_W), .AW(POS_W)) u_by_pair (
    .clk(clk), .we(bp_we), .waddr(cnt_dec[POS_W-1:0]), .wdata(jsel),
    .raddr0(bp_raddr), .raddr1(bp_raddr), .rdata0(bp_rd), .rdata1()
  );

endmodule

### rtl/core/slc_query.sv
// Query walker: bound checks, then power-of-two block compares.
module slc_query (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       go,
  input  logic                       ready,
  input  logic [slc_pkg::LEN_W-1:0]  n,
  input  logic [slc_pkg::LEN_W-1:0]  first_start,
  input  logic [slc_pkg::LEN_W-1:0]  first_end,
  input  logic [slc_pkg::LEN_W-1:0]  second_start,
  input  logic [slc_pkg::LEN_W-1:0]  second_end,
  output slc_pkg::rank_port_t        rank_port,
  input  logic [slc_pkg::RANK_W-1:0] rank_rd0,
  input  logic [slc_pkg::RANK_W-1:0] rank_rd1,
  output logic                       busy,
  output logic                       done,
  output logic [1:0]                 verdict
);
  import slc_pkg::*;

  localparam logic [1:0] Q_IDLE = 2'd0;
  localparam logic [1:0] Q_SCAN = 2'd1;
  localparam logic [1:0] Q_CMP  = 2'd2;

  logic [1:0]       state;
  logic [LVL_W-1:0] lvl;
  logic [POS_W-1:0] pa, pc;
  logic [LEN_W-1:0] min_l, l1, l2;

  logic             bad;
  logic [LEN_W-1:0] l1_in, l2_in;
  logic [1:0]       len_verdict;

  assign bad = !ready || (first_start == '0) || (second_start == '0) ||
               (first_end < first_start) || (second_end < second_start) ||
               (first_end > n) || (second_end > n);
  assign l1_in = first_end - first_start + LEN_W'(1);
  assign l2_in = second_end - second_start + LEN_W'(1);
  assign len_verdict = (l1 < l2) ? VERDICT_LESS :
                       (l1 > l2) ? VERDICT_GREATER : VERDICT_EQUAL;
  assign busy = (state != Q_IDLE);

  always_comb begin
    rank_port        = '0;
    rank_port.raddr0 = rank_addr(lvl, pa);
    rank_port.raddr1 = rank_addr(lvl, pc);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= Q_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        Q_IDLE: begin
          if (go) begin
            if (bad) begin
              verdict <= VERDICT_INVALID;
              done    <= 1'b1;
            end else begin
              l1    <= l1_in;
              l2    <= l2_in;
              min_l <= (l1_in < l2_in) ? l1_in : l2_in;
              pa    <= POS_W'(first_start - LEN_W'(1));
              pc    <= POS_W'(second_start - LEN_W'(1));
              lvl   <= LVL_W'(LEVELS - 1);
              state <= Q_SCAN;
            end
          end
        end
        Q_SCAN: begin
          if (min_l[lvl]) begin
            state <= Q_CMP;
          end else if (lvl == '0) begin
            verdict <= len_verdict;
            done    <= 1'b1;
            state   <= Q_IDLE;
          end else begin
            lvl <= lvl - LVL_W'(1);
          end
        end
        Q_CMP: begin
          if (rank_rd0 != rank_rd1) begin
            verdict <= (rank_rd0 < rank_rd1) ? VERDICT_LESS : VERDICT_GREATER;
            done    <= 1'b1;
            state   <= Q_IDLE;
          end else if (lvl == '0) begin
            verdict <= len_verdict;
            done    <= 1'b1;
            state   <= Q_IDLE;
          end else begin
            pa    <= pa + (POS_W'(1) << lvl);
            pc    <= pc + (POS_W'(1) << lvl);
            lvl   <= lvl - LVL_W'(1);
            state <= Q_SCAN;
          end
        end
        default: state <= Q_IDLE;
      endcase
    end
  end

endmodule
